// ===== hdl/rbee_pkg.sv =====
// ----------------------------------------------------------------------------
// rbee_pkg
// Shared types, widths and coordinate helpers for the ray/box entry-exit unit
// ----------------------------------------------------------------------------
`default_nettype none

package rbee_pkg;

  localparam int COORD_W    = 32;
  localparam int AXES       = 3;
  localparam int FACE_COUNT = 6;
  localparam int LANES      = FACE_COUNT * 2;
  localparam int CAND       = FACE_COUNT + 1;
  localparam int NUM_W      = COORD_W + 1;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int QUOT_W     = 35;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int PT_W       = COORD_W + 4;
  localparam int CNT_W      = 3;

  localparam logic [QUOT_W-1:0] QUOT_LIMIT = QUOT_W'(1) << (QUOT_W - 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t box_x_min;
    coord_t box_x_max;
    coord_t box_y_min;
    coord_t box_y_max;
    coord_t box_z_min;
    coord_t box_z_max;
  } ray_in_t;

  typedef struct packed {
    logic              hit;
    coord_t            entry_x;
    coord_t            entry_y;
    coord_t            entry_z;
    coord_t            exit_x;
    coord_t            exit_y;
    coord_t            exit_z;
    logic [CNT_W-1:0]  point_count;
  } ray_out_t;

  function automatic coord_t org_of(ray_in_t r, int k);
    case (k)
      0:       org_of = r.origin_x;
      1:       org_of = r.origin_y;
      default: org_of = r.origin_z;
    endcase
  endfunction

  function automatic coord_t dir_of(ray_in_t r, int k);
    case (k)
      0:       dir_of = r.dir_x;
      1:       dir_of = r.dir_y;
      default: dir_of = r.dir_z;
    endcase
  endfunction

  function automatic coord_t lo_of(ray_in_t r, int k);
    case (k)
      0:       lo_of = r.box_x_min;
      1:       lo_of = r.box_y_min;
      default: lo_of = r.box_z_min;
    endcase
  endfunction

  function automatic coord_t hi_of(ray_in_t r, int k);
    case (k)
      0:       hi_of = r.box_x_max;
      1:       hi_of = r.box_y_max;
      default: hi_of = r.box_z_max;
    endcase
  endfunction

  // faces run min, max per axis
  function automatic coord_t bound_of(ray_in_t r, int f);
    if ((f & 1) != 0) begin
      bound_of = hi_of(r, f >> 1);
    end else begin
      bound_of = lo_of(r, f >> 1);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rbee_div_lane.sv =====
// ----------------------------------------------------------------------------
// rbee_div_lane
// Pipelined restoring divider, one quotient bit per stage, clamped quotient
// ----------------------------------------------------------------------------
`default_nettype none

module rbee_div_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rbee_pkg::PROD_W-1:0]       prod_i,
  input  logic [rbee_pkg::COORD_W-1:0]      den_i,
  output logic [rbee_pkg::QUOT_W-1:0]       quot_o
);

  localparam int HI_W = rbee_pkg::PROD_W - rbee_pkg::QUOT_W;
  localparam int CW   = rbee_pkg::COORD_W;
  localparam int QW   = rbee_pkg::QUOT_W;
  localparam int NST  = rbee_pkg::DIV_STEPS;

  logic          ovf_r [0:NST];
  logic [CW-1:0] den_r [0:NST];
  logic [CW-1:0] rem_r [0:NST];
  logic [QW-1:0] qs_r  [0:NST];
  logic          ovf_nxt;

  // quotient at or above 2^QW if the upper part already reaches the divisor
  assign ovf_nxt = {{(CW-HI_W){1'b0}}, prod_i[rbee_pkg::PROD_W-1:QW]} >= den_i;

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= ovf_nxt;
      den_r[0] <= den_i;
      rem_r[0] <= ovf_nxt ? '0 : {{(CW-HI_W){1'b0}}, prod_i[rbee_pkg::PROD_W-1:QW]};
      qs_r[0]  <= prod_i[QW-1:0];
    end
  end

  for (genvar j = 1; j <= NST; j++) begin : g_step
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_r[j-1], qs_r[j-1][QW-1]};
      diff  = trial - {1'b0, den_r[j-1]};
      ge    = trial >= {1'b0, den_r[j-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[j] <= ovf_r[j-1];
        den_r[j] <= den_r[j-1];
        rem_r[j] <= ge ? diff[CW-1:0] : trial[CW-1:0];
        qs_r[j]  <= {qs_r[j-1][QW-2:0], ge};
      end
    end
  end

  assign quot_o = (ovf_r[NST] || (qs_r[NST] > rbee_pkg::QUOT_LIMIT)) ?
                  rbee_pkg::QUOT_LIMIT : qs_r[NST];

endmodule

`default_nettype wire

// ===== hdl/ray_box_entry_exit.sv =====
// ----------------------------------------------------------------------------
// ray_box_entry_exit
// Ray line against axis-aligned box: entry point, exit point and point count
// ----------------------------------------------------------------------------
//  channel | direction | ports                         | word
//  in      | input     | in_valid, in_stall, in_word   | ray origin, dir, box
//  out     | output    | out_valid, out_stall, out_word| hit, entry, exit, count
//
//  one word per cycle while in_stall is low. words pass the input, prep and
//  multiply registers, the 36-stage divider lanes (an entry stage, then one
//  quotient bit a stage), then the point and output registers.
//  reset clears valid bits only; payload registers are not reset.
//  a word behind a stalled output is held in the skid; in_stall rises only then.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_entry_exit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rbee_pkg::ray_in_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rbee_pkg::ray_out_t  out_word
);

  localparam int CW     = rbee_pkg::COORD_W;
  localparam int PW     = rbee_pkg::PT_W;
  localparam int LANES  = rbee_pkg::LANES;
  localparam int FACES  = rbee_pkg::FACE_COUNT;
  localparam int AXES   = rbee_pkg::AXES;
  localparam int CAND   = rbee_pkg::CAND;
  localparam int ST_DIV = 3;
  localparam int ST_PT  = ST_DIV + rbee_pkg::DIV_STEPS + 1;
  localparam int NS     = ST_PT + 1;

  logic                          adv;
  logic [NS-1:0]                 v_r;
  rbee_pkg::ray_in_t             ray_r [0:NS-1];
  logic [LANES-1:0]              neg_r [1:NS-1];
  logic [LANES-1:0]              neg_nxt;

  logic [rbee_pkg::NUM_W-1:0]    nmag_nxt [0:FACES-1];
  logic [rbee_pkg::NUM_W-1:0]    nmag_r   [0:FACES-1];
  logic [CW-1:0]                 dmag_nxt [0:AXES-1];
  logic [CW-1:0]                 dmag_r   [0:AXES-1];
  logic [rbee_pkg::PROD_W-1:0]   prod_nxt [0:LANES-1];
  logic [rbee_pkg::PROD_W-1:0]   prod_r   [0:LANES-1];
  logic [CW-1:0]                 den_nxt  [0:LANES-1];
  logic [CW-1:0]                 den_r    [0:LANES-1];
  logic [rbee_pkg::QUOT_W-1:0]   quot_w   [0:LANES-1];

  logic [CAND-1:0]               cnt_nxt;
  logic [CAND-1:0]               cnt_r;
  rbee_pkg::coord_t              pt_nxt [0:CAND-1][0:AXES-1];
  rbee_pkg::coord_t              pt_r   [0:CAND-1][0:AXES-1];

  rbee_pkg::ray_out_t            res;
  rbee_pkg::ray_out_t            out_r;
  rbee_pkg::ray_out_t            skid_r;
  logic                          out_v_r;
  logic                          skid_v_r;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray_r[0] <= in_word;
      for (int s = 1; s < NS; s++) begin
        ray_r[s] <= ray_r[s-1];
      end
      neg_r[1] <= neg_nxt;
      for (int s = 2; s < NS; s++) begin
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  // prep: direction magnitudes, plane distance magnitudes and result signs
  always_comb begin
    logic [CW-1:0]             dv;
    logic [CW-1:0]             da;
    logic [CW-1:0]             dk;
    logic [CW-1:0]             bv;
    logic [CW-1:0]             ov;
    logic [rbee_pkg::NUM_W-1:0] num;
    int                        a;
    int                        k;
    neg_nxt = '0;
    for (int x = 0; x < AXES; x++) begin
      dv = rbee_pkg::dir_of(ray_r[0], x);
      dmag_nxt[x] = dv[CW-1] ? (~dv + 1'b1) : dv;
    end
    for (int f = 0; f < FACES; f++) begin
      a   = f >> 1;
      bv  = rbee_pkg::bound_of(ray_r[0], f);
      ov  = rbee_pkg::org_of(ray_r[0], a);
      da  = rbee_pkg::dir_of(ray_r[0], a);
      num = {bv[CW-1], bv} - {ov[CW-1], ov};
      nmag_nxt[f] = num[rbee_pkg::NUM_W-1] ? (~num + 1'b1) : num;
      for (int j = 0; j < 2; j++) begin
        k  = (j < a) ? j : j + 1;
        dk = rbee_pkg::dir_of(ray_r[0], k);
        neg_nxt[2*f+j] = dk[CW-1] ^ num[rbee_pkg::NUM_W-1] ^ da[CW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nmag_r <= nmag_nxt;
      dmag_r <= dmag_nxt;
    end
  end

  // off-axis direction times plane distance, one product per lane
  always_comb begin
    int a;
    int k;
    for (int f = 0; f < FACES; f++) begin
      a = f >> 1;
      for (int j = 0; j < 2; j++) begin
        k = (j < a) ? j : j + 1;
        prod_nxt[2*f+j] = rbee_pkg::PROD_W'(dmag_r[k]) *
                          rbee_pkg::PROD_W'(nmag_r[f]);
        den_nxt[2*f+j]  = dmag_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      den_r  <= den_nxt;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rbee_div_lane u_div (
      .clk    (clk),
      .en     (adv),
      .prod_i (prod_r[l]),
      .den_i  (den_r[l]),
      .quot_o (quot_w[l])
    );
  end

  // origin and face points, and the inclusive box test at widened precision
  always_comb begin
    logic signed [PW-1:0] p   [0:AXES-1];
    logic signed [PW-1:0] lo  [0:AXES-1];
    logic signed [PW-1:0] hi  [0:AXES-1];
    logic signed [PW-1:0] og  [0:AXES-1];
    logic signed [PW-1:0] qq;
    rbee_pkg::coord_t     c;
    rbee_pkg::coord_t     da;
    logic                 in_box;
    int                   a;
    int                   l;
    for (int k = 0; k < AXES; k++) begin
      c     = rbee_pkg::lo_of(ray_r[ST_PT-1], k);
      lo[k] = {{(PW-CW){c[CW-1]}}, c};
      c     = rbee_pkg::hi_of(ray_r[ST_PT-1], k);
      hi[k] = {{(PW-CW){c[CW-1]}}, c};
      c     = rbee_pkg::org_of(ray_r[ST_PT-1], k);
      og[k] = {{(PW-CW){c[CW-1]}}, c};
      pt_nxt[0][k] = c;
    end
    in_box = 1'b1;
    for (int k = 0; k < AXES; k++) begin
      if (og[k] < lo[k] || og[k] > hi[k]) begin
        in_box = 1'b0;
      end
    end
    cnt_nxt[0] = in_box;
    for (int f = 0; f < FACES; f++) begin
      a  = f >> 1;
      da = rbee_pkg::dir_of(ray_r[ST_PT-1], a);
      for (int k = 0; k < AXES; k++) begin
        if (k == a) begin
          c    = rbee_pkg::bound_of(ray_r[ST_PT-1], f);
          p[k] = {{(PW-CW){c[CW-1]}}, c};
        end else begin
          l    = 2 * f + ((k < a) ? k : k - 1);
          qq   = {{(PW-rbee_pkg::QUOT_W){1'b0}}, quot_w[l]};
          p[k] = neg_r[ST_PT-1][l] ? (og[k] - qq) : (og[k] + qq);
        end
        pt_nxt[f+1][k] = p[k][CW-1:0];
      end
      in_box = (da != '0);
      for (int k = 0; k < AXES; k++) begin
        if (p[k] < lo[k] || p[k] > hi[k]) begin
          in_box = 1'b0;
        end
      end
      cnt_nxt[f+1] = in_box;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt_r  <= cnt_nxt;
      pt_r   <= pt_nxt;
    end
  end

  // first counted point is the entry, last one the exit
  always_comb begin
    rbee_pkg::coord_t      en_p [0:AXES-1];
    rbee_pkg::coord_t      ex_p [0:AXES-1];
    logic [rbee_pkg::CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < AXES; k++) begin
      en_p[k] = '0;
      ex_p[k] = '0;
    end
    for (int i = CAND - 1; i >= 0; i--) begin
      if (cnt_r[i]) begin
        for (int k = 0; k < AXES; k++) begin
          en_p[k] = pt_r[i][k];
        end
      end
    end
    for (int i = 0; i < CAND; i++) begin
      if (cnt_r[i]) begin
        for (int k = 0; k < AXES; k++) begin
          ex_p[k] = pt_r[i][k];
        end
      end
      n = n + rbee_pkg::CNT_W'(cnt_r[i]);
    end
    res.hit         = (n != '0);
    res.entry_x     = en_p[0];
    res.entry_y     = en_p[1];
    res.entry_z     = en_p[2];
    res.exit_x      = ex_p[0];
    res.exit_y      = ex_p[1];
    res.exit_z      = ex_p[2];
    res.point_count = n;
  end

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_r   <= res;
        out_v_r <= v_r[ST_PT];
      end
    end else if (v_r[ST_PT] && adv) begin
      skid_r   <= res;
      skid_v_r <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule

`default_nettype wire

// ===== hdl/rbee_checker.sv =====
// ----------------------------------------------------------------------------
// rbee_checker
// Port-level checks on the ray/box entry-exit unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rbee_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rbee_pkg::ray_out_t  out_word
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.hit == (out_word.point_count != '0)))
    else $error("hit disagrees with point count");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.hit |->
      out_word.entry_x == '0 && out_word.entry_y == '0 && out_word.entry_z == '0 &&
      out_word.exit_x == '0 && out_word.exit_y == '0 && out_word.exit_z == '0)
    else $error("miss with nonzero point");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.point_count == 3'd1 |->
      out_word.exit_x == out_word.entry_x && out_word.exit_y == out_word.entry_y &&
      out_word.exit_z == out_word.entry_z)
    else $error("single point with exit apart from entry");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall after reset");

endmodule

bind ray_box_entry_exit rbee_checker u_rbee_checker (.*);

`default_nettype wire
